// File: design/bbl_pkg.sv
package bbl_pkg;

  localparam int SAMPLE_WIDTH    = 16;
  localparam int COEF_WIDTH      = 24;
  localparam int WARM_GAIN_WIDTH = 23;
  localparam int COEF_FRAC_BITS  = 22;
  localparam int WARMUP_SAMPLES  = 3;
  localparam int CFG_IDX_WIDTH   = 3;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_WIDTH-1:0] REG_FF_GAIN_0   = 3'd0;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_FF_GAIN_1   = 3'd1;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_FF_GAIN_2   = 3'd2;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_FB_GAIN_1   = 3'd3;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_FB_GAIN_2   = 3'd4;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_WARMUP_GAIN = 3'd5;

  typedef struct packed {
    logic signed [COEF_WIDTH-1:0] ff_gain_0;
    logic signed [COEF_WIDTH-1:0] ff_gain_1;
    logic signed [COEF_WIDTH-1:0] ff_gain_2;
    logic signed [COEF_WIDTH-1:0] fb_gain_1;
    logic signed [COEF_WIDTH-1:0] fb_gain_2;
    logic [WARM_GAIN_WIDTH-1:0]   warmup_gain;
  } coef_t;

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] sample;
    logic                           warm;
  } result_t;

endpackage

// File: design/butterworth_biquad_lowpass.sv
// channel   direction  transfer when           payload
// in_       input      in_valid & in_ready     in_sample_in
// out_      output     out_valid & out_ready   out_sample_out, out_in_warmup
// cfg_      input      cfg_valid & cfg_ready   cfg_index, cfg_data
//
// one sample a cycle sustained while out_ready stays high; out_valid rises after the
// input transfer has passed the input register and then the result register around the
// five-multiply adder tree whose output feeds back into the delay line.
// reset (rst_n low, synchronous) clears coefficients, delay line, warm-up count.
// a stall on out_ holds the result register; in_ready drops only when both
// registers are full and out_ready is low. cfg_ready is always high.
module butterworth_biquad_lowpass
  import bbl_pkg::*;
(
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic signed [SAMPLE_WIDTH-1:0] in_sample_in,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [SAMPLE_WIDTH-1:0] out_sample_out,
  output logic                           out_in_warmup,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [CFG_IDX_WIDTH-1:0]       cfg_index,
  input  logic [COEF_WIDTH-1:0]          cfg_data
);

  coef_t   coef;
  result_t res;

  logic                           in_valid_r, in_valid_nxt;
  logic signed [SAMPLE_WIDTH-1:0] in_sample_r;
  logic                           out_valid_r, out_valid_nxt;
  result_t                        out_res_r;
  logic                           advance;

  bbl_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .coef      (coef)
  );

  bbl_datapath u_datapath (
    .clk   (clk),
    .rst_n (rst_n),
    .coef  (coef),
    .step  (advance),
    .x     (in_sample_r),
    .res   (res)
  );

  // held sample moves on when the result register is free or being drained
  assign advance  = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || advance;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_valid && in_ready) begin
      in_valid_nxt = 1'b1;
    end else if (advance) begin
      in_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_sample_r <= in_sample_in;
    end
    if (advance) begin
      out_res_r <= res;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_sample_out = out_res_r.sample;
  assign out_in_warmup  = out_res_r.warm;

  a_advance_fills: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r)
    else $error("result register empty after a step");

  a_held_sample: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && !advance) |=> in_valid_r && $stable(in_sample_r))
    else $error("held input sample lost before its step");

  a_no_step_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> !advance)
    else $error("step overwrote a pending result");

endmodule

// File: design/bbl_cfg.sv
module bbl_cfg
  import bbl_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_WIDTH-1:0] cfg_index,
  input  logic [COEF_WIDTH-1:0]    cfg_data,
  output coef_t                    coef
);

  coef_t coef_r, coef_nxt;

  assign cfg_ready = 1'b1;
  assign coef      = coef_r;

  always_comb begin
    coef_nxt = coef_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        REG_FF_GAIN_0:   coef_nxt.ff_gain_0   = signed'(cfg_data);
        REG_FF_GAIN_1:   coef_nxt.ff_gain_1   = signed'(cfg_data);
        REG_FF_GAIN_2:   coef_nxt.ff_gain_2   = signed'(cfg_data);
        REG_FB_GAIN_1:   coef_nxt.fb_gain_1   = signed'(cfg_data);
        REG_FB_GAIN_2:   coef_nxt.fb_gain_2   = signed'(cfg_data);
        REG_WARMUP_GAIN: coef_nxt.warmup_gain = cfg_data[WARM_GAIN_WIDTH-1:0];
        default:         coef_nxt = coef_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r <= '0;
    end else begin
      coef_r <= coef_nxt;
    end
  end

endmodule

// File: design/bbl_datapath.sv
module bbl_datapath
  import bbl_pkg::*;
(
  input  logic                           clk,
  input  logic                           rst_n,
  input  coef_t                          coef,
  input  logic                           step,
  input  logic signed [SAMPLE_WIDTH-1:0] x,
  output result_t                        res
);

  localparam int PROD_W = SAMPLE_WIDTH + COEF_WIDTH;
  localparam int DIFF_W = SAMPLE_WIDTH + 1;
  localparam int WPROD_W = DIFF_W + WARM_GAIN_WIDTH + 1;
  localparam int ACC_W  = PROD_W + 4;
  localparam logic signed [ACC_W-1:0] ROUND_ADD = ACC_W'(1) <<< (COEF_FRAC_BITS - 1);
  localparam logic signed [ACC_W-1:0] SAT_HI = (ACC_W'(1) <<< (SAMPLE_WIDTH - 1)) - ACC_W'(1);
  localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI - ACC_W'(1);
  localparam logic [1:0] WARM_LIMIT = 2'(WARMUP_SAMPLES);

  logic [1:0]                     warm_count_r, warm_count_nxt;
  logic signed [SAMPLE_WIDTH-1:0] x1_r, x2_r, y1_r, y2_r;
  logic                           warm;
  logic signed [PROD_W-1:0]       p_ff0, p_ff1, p_ff2, p_fb1, p_fb2;
  logic signed [ACC_W-1:0]        acc, acc_rnd;
  logic signed [DIFF_W-1:0]       diff;
  logic signed [WPROD_W-1:0]      p_warm;
  logic signed [ACC_W-1:0]        warm_sum;
  logic signed [ACC_W-1:0]        pre_sat;
  logic signed [SAMPLE_WIDTH-1:0] y;

  function automatic logic signed [ACC_W-1:0] round_frac(input logic signed [ACC_W-1:0] v);
    round_frac = (v + ROUND_ADD) >>> COEF_FRAC_BITS;
  endfunction

  assign warm = (warm_count_r < WARM_LIMIT);

  assign p_ff0 = x    * coef.ff_gain_0;
  assign p_ff1 = x1_r * coef.ff_gain_1;
  assign p_ff2 = x2_r * coef.ff_gain_2;
  assign p_fb1 = y1_r * coef.fb_gain_1;
  assign p_fb2 = y2_r * coef.fb_gain_2;

  assign acc = ACC_W'(p_ff0) + ACC_W'(p_ff1) + ACC_W'(p_ff2)
             + ACC_W'(p_fb1) + ACC_W'(p_fb2);
  assign acc_rnd = round_frac(acc);

  // first-order smoother, gain is unsigned so widen with a zero sign bit
  assign diff     = DIFF_W'(x) - DIFF_W'(y1_r);
  assign p_warm   = diff * signed'({1'b0, coef.warmup_gain});
  assign warm_sum = ACC_W'(y1_r) + round_frac(ACC_W'(p_warm));

  assign pre_sat = warm ? warm_sum : acc_rnd;

  always_comb begin
    if (pre_sat > SAT_HI) begin
      y = SAT_HI[SAMPLE_WIDTH-1:0];
    end else if (pre_sat < SAT_LO) begin
      y = SAT_LO[SAMPLE_WIDTH-1:0];
    end else begin
      y = pre_sat[SAMPLE_WIDTH-1:0];
    end
  end

  assign res.sample = y;
  assign res.warm   = warm;

  always_comb begin
    warm_count_nxt = warm_count_r;
    if (step && warm) begin
      warm_count_nxt = warm_count_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      warm_count_r <= '0;
      x1_r         <= '0;
      x2_r         <= '0;
      y1_r         <= '0;
      y2_r         <= '0;
    end else begin
      warm_count_r <= warm_count_nxt;
      if (step) begin
        x2_r <= x1_r;
        x1_r <= x;
        y2_r <= y1_r;
        y1_r <= y;
      end
    end
  end

  a_warm_bound: assert property (@(posedge clk) disable iff (!rst_n)
    warm_count_r <= WARM_LIMIT)
    else $error("warm-up count past its limit");

  a_warm_done_sticks: assert property (@(posedge clk) disable iff (!rst_n)
    !warm |=> !warm)
    else $error("warm-up path came back after it ended");

  a_delay_shift: assert property (@(posedge clk) disable iff (!rst_n)
    step |=> (x2_r == $past(x1_r)) && (y2_r == $past(y1_r)))
    else $error("delay line did not shift on a step");

endmodule
